### rtl/core/srtf_pkg.sv
`default_nettype none

package srtf_pkg;

    localparam int IDX_FIELD_W = 4;
    localparam int DATA_W      = 16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // request as it leaves the front queue
    typedef struct packed {
        logic                   kind;
        logic                   load_ok;
        logic [IDX_FIELD_W-1:0] proc_index;
        logic [DATA_W-1:0]      arrival;
        logic [DATA_W-1:0]      burst;
    } req_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] selected_index;
        logic [DATA_W-1:0]      tick_time;
        logic                   idle;
        logic                   finished;
        logic                   all_done;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } exec_state_t;

endpackage

`default_nettype wire

### rtl/core/srtf_front.sv
`default_nettype none

module srtf_front
    import srtf_pkg::*;
#(
    parameter int MAX_PROCS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   kind,
    input  wire logic [IDX_FIELD_W-1:0] proc_index,
    input  wire logic [DATA_W-1:0]      arrival_time,
    input  wire logic [DATA_W-1:0]      burst_time,
    output logic                        req_valid,
    output req_t                        req,
    input  wire logic                   req_take
);

    req_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    req_t       in_req;
    logic       do_push;
    logic       do_pop;

    // classify: flag loads that fall outside the table
    always_comb
    begin
        in_req.kind       = kind;
        in_req.load_ok    = (32'(proc_index) < MAX_PROCS);
        in_req.proc_index = proc_index;
        in_req.arrival    = arrival_time;
        in_req.burst      = burst_time;
    end

    assign full      = (count_reg == 2'd2);
    assign req_valid = (count_reg != 2'd0);
    assign req       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/core/srtf_exec.sv
`default_nettype none

module srtf_exec
    import srtf_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    input  wire req_t   req,
    output logic        req_take,
    output logic        res_push,
    output result_t     res,
    input  wire logic   res_full
);

    localparam int IDX_W  = $clog2(MAX_PROCS);
    localparam int SCAN_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int CMP_W  = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;

    exec_state_t state_reg;
    exec_state_t state_next;

    logic [DATA_W-1:0] arrival_mem   [MAX_PROCS];
    logic [DATA_W-1:0] remaining_mem [MAX_PROCS];

    logic [SCAN_W-1:0]    scan_cnt_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_slot_reg;
    logic [DATA_W-1:0]    arr_rd_reg;
    logic [DATA_W-1:0]    rem_rd_reg;
    logic                 have_reg;
    logic [IDX_W-1:0]     best_slot_reg;
    logic [DATA_W-1:0]    best_rem_reg;
    logic [DATA_W-1:0]    best_arr_reg;
    logic [MAX_PROCS-1:0] valid_reg;
    logic [MAX_PROCS-1:0] done_reg;
    logic [CNT_W-1:0]     active_cnt_reg;
    logic [TIME_BITS-1:0] time_reg;
    result_t              res_reg;

    logic                    scan_issue;
    logic                    scan_end;
    logic                    load_we;
    logic                    tick_we;
    logic                    tick_start;
    logic [IDX_W-1:0]        scan_addr;
    logic [IDX_W+IDX_FIELD_W-1:0] load_slot_ext;
    logic [IDX_W-1:0]        load_slot;
    logic                    old_active;
    logic                    new_active;
    logic                    slot_ready;
    logic                    better;
    logic                    fin;
    logic [DATA_W-1:0]       rem_dec;
    logic [CNT_W-1:0]        active_after;
    logic [IDX_W+IDX_FIELD_W-1:0] sel_ext;
    logic [TIME_BITS+DATA_W-1:0]  time_ext;
    result_t                 res_calc;

    assign scan_addr     = scan_cnt_reg[IDX_W-1:0];
    assign scan_end      = (scan_cnt_reg == SCAN_W'(MAX_PROCS));
    assign load_slot_ext = {{IDX_W{1'b0}}, req.proc_index};
    assign load_slot     = load_slot_ext[IDX_W-1:0];
    assign old_active    = valid_reg[load_slot] && !done_reg[load_slot];
    assign new_active    = (req.burst != '0);

    assign slot_ready = rd_vld_reg && valid_reg[rd_slot_reg] && !done_reg[rd_slot_reg]
                        && (CMP_W'(arr_rd_reg) <= CMP_W'(time_reg));
    assign better     = !have_reg || (rem_rd_reg < best_rem_reg)
                        || ((rem_rd_reg == best_rem_reg) && (arr_rd_reg < best_arr_reg));

    assign fin          = have_reg && (best_rem_reg == DATA_W'(1));
    assign rem_dec      = best_rem_reg - DATA_W'(1);
    assign active_after = active_cnt_reg - CNT_W'(fin);
    assign sel_ext      = {{IDX_FIELD_W{1'b0}}, best_slot_reg};
    assign time_ext     = {{DATA_W{1'b0}}, time_reg};

    always_comb
    begin
        res_calc.selected_index = have_reg ? sel_ext[IDX_FIELD_W-1:0] : '0;
        res_calc.tick_time      = time_ext[DATA_W-1:0];
        res_calc.idle           = !have_reg;
        res_calc.finished       = fin;
        res_calc.all_done       = (active_after == '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req.kind == KIND_TICK)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_take   = 1'b0;
        tick_start = 1'b0;
        load_we    = 1'b0;
        scan_issue = 1'b0;
        tick_we    = 1'b0;
        res_push   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_take   = req_valid;
                tick_start = req_valid && (req.kind == KIND_TICK);
                load_we    = req_valid && (req.kind == KIND_LOAD) && req.load_ok;
            end
            ST_SCAN:
            begin
                scan_issue = !scan_end;
            end
            ST_WRITE:
            begin
                tick_we = have_reg;
            end
            ST_EMIT:
            begin
                res_push = !res_full;
            end
            default:
            begin
                req_take = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    // table memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            arrival_mem[load_slot]   <= req.arrival;
            remaining_mem[load_slot] <= req.burst;
        end
        else if (tick_we)
        begin
            remaining_mem[best_slot_reg] <= rem_dec;
        end
        if (scan_issue)
        begin
            arr_rd_reg <= arrival_mem[scan_addr];
            rem_rd_reg <= remaining_mem[scan_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= scan_addr;
        if (slot_ready && better)
        begin
            best_slot_reg <= rd_slot_reg;
            best_rem_reg  <= rem_rd_reg;
            best_arr_reg  <= arr_rd_reg;
        end
        if (state_reg == ST_WRITE)
        begin
            res_reg <= res_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            have_reg       <= 1'b0;
            valid_reg      <= '0;
            done_reg       <= '0;
            active_cnt_reg <= '0;
            time_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= scan_issue;
            if (tick_start)
            begin
                scan_cnt_reg <= '0;
                have_reg     <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
                end
                if (slot_ready && better)
                begin
                    have_reg <= 1'b1;
                end
            end
            if (load_we)
            begin
                valid_reg[load_slot] <= 1'b1;
                done_reg[load_slot]  <= !new_active;
                active_cnt_reg <= active_cnt_reg - CNT_W'(old_active) + CNT_W'(new_active);
            end
            if (tick_we && fin)
            begin
                done_reg[best_slot_reg] <= 1'b1;
            end
            if (state_reg == ST_WRITE)
            begin
                active_cnt_reg <= active_after;
                // saturate at the top of the time range
                if (time_reg != '1)
                begin
                    time_reg <= time_reg + TIME_BITS'(1);
                end
            end
        end
    end

    a_active_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_cnt_reg) <= MAX_PROCS)
        else $error("active count exceeds table size");

    a_pick_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && have_reg) |-> valid_reg[best_slot_reg])
        else $error("picked slot not loaded");

    a_pick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && have_reg) |-> (best_rem_reg != '0))
        else $error("picked slot has no remaining time");

    a_all_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_reg.all_done) |-> (active_cnt_reg == '0))
        else $error("all_done reported with active slots");

endmodule

`default_nettype wire

### rtl/core/srtf_outq.sv
`default_nettype none

module srtf_outq
    import srtf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_push,
    input  wire result_t res,
    output logic         res_full,
    output logic         empty,
    input  wire logic    pop,
    output result_t      head
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = entry_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/core/shortest_remaining_time_scheduler.sv
// Preemptive shortest-remaining-time scheduler over a table of MAX_PROCS slots.
// Input channel (push/full): kind 0 loads slot proc_index with arrival_time and
// burst_time (slots beyond the table are dropped); kind 1 is one scheduling tick.
// Result channel (empty/pop): one result per tick, none per load; the oldest
// result sits on the result ports while empty is low.
// A two-entry request queue feeds the executor, and a two-entry result queue
// follows it, so either side may stall without losing requests.
// Flow: the executor takes a load in its idle state. A tick scans the table one
// slot per cycle through the single read port of the table memory, then writes
// the picked slot back and emits its result, holding the executor until the
// result is queued. The executor takes no new request while a tick is in
// progress; loads are taken at one per cycle while it is idle.
// Reset clears all slots to not loaded, the time counter to zero and both
// queues to empty; no clearing pass is needed.
// When pop stays low the result queue fills, the executor holds its finished
// tick, and full rises once the request queue is full as well.
`default_nettype none

module shortest_remaining_time_scheduler
    import srtf_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   kind,
    input  wire logic [IDX_FIELD_W-1:0] proc_index,
    input  wire logic [DATA_W-1:0]      arrival_time,
    input  wire logic [DATA_W-1:0]      burst_time,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [IDX_FIELD_W-1:0]      selected_index,
    output logic [DATA_W-1:0]           tick_time,
    output logic                        idle,
    output logic                        finished,
    output logic                        all_done
);

    logic    req_valid;
    req_t    req;
    logic    req_take;
    logic    res_push;
    result_t res;
    logic    res_full;
    result_t head;

    srtf_front #(
        .MAX_PROCS (MAX_PROCS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .proc_index   (proc_index),
        .arrival_time (arrival_time),
        .burst_time   (burst_time),
        .req_valid    (req_valid),
        .req          (req),
        .req_take     (req_take)
    );

    srtf_exec #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_BITS (TIME_BITS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    srtf_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign selected_index = head.selected_index;
    assign tick_time      = head.tick_time;
    assign idle           = head.idle;
    assign finished       = head.finished;
    assign all_done       = head.all_done;

endmodule

`default_nettype wire
